// File: rtl/core/scfla_pkg.sv
// Shared constants, types and control bundles of the size-class allocator.
`default_nettype none

package scfla_pkg;

    // Heap geometry in 8-byte words
    localparam int ARENA_WORDS       = 512;
    localparam int HEAP_WORDS        = 32768;
    localparam int LARGE_BLOCK_WORDS = 2048;
    localparam int MAX_CLASSES       = 32;

    localparam int BYTE_SH  = 3;
    localparam int WORD_W   = $clog2(HEAP_WORDS);
    localparam int ARENA_SH = $clog2(ARENA_WORDS);
    localparam int AIDX_W   = WORD_W - ARENA_SH;
    localparam int CLS_W    = $clog2(MAX_CLASSES);
    localparam int ADDR_W   = WORD_W + BYTE_SH;
    localparam int SIZE_W   = 20;
    localparam int SCLS_W   = SIZE_W - BYTE_SH;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    // A large block links onward only while the next one still fits below the cap
    localparam int LARGE_CONT_LIMIT = HEAP_WORDS - 2 * LARGE_BLOCK_WORDS;
    localparam int LARGE_MASK       = LARGE_BLOCK_WORDS - 1;

    localparam logic [CLS_W-1:0] LAST_CLASS_RST = CLS_W'(15);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ALLOC   = 3'd0,
        STAT_MOVED   = 3'd1,
        STAT_KEPT    = 3'd2,
        STAT_FREED   = 3'd3,
        STAT_NULL    = 3'd4,
        STAT_IGNORED = 3'd5
    } status_t;

    // Link memory read address source
    typedef enum logic [1:0] {
        RD_NONE     = 2'd0,
        RD_BASE_NEW = 2'd1,
        RD_BASE_OLD = 2'd2,
        RD_LINK     = 2'd3
    } rd_sel_t;

    // Link memory write address and data source
    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_SWEEP    = 3'd1,
        WR_BASE_NEW = 3'd2,
        WR_HEAD_CLR = 3'd3,
        WR_WORD     = 3'd4,
        WR_BASE_OLD = 3'd5
    } wr_sel_t;

    typedef struct packed {
        logic    cfg_load;
        logic    load_in;
        logic    sweep_step;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    load_head;
        logic    load_out;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             addr_present;
        logic             size_zero;
        logic             blk_invalid;
        logic             same_class;
        logic             head_zero;
        logic             sweep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/scfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/scfla_dp.sv
// Allocator datapath: request registers, class decode, link memory, chain builder, result.
`default_nettype none

module scfla_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire scfla_pkg::dp_cmd_t                 ctl,
    output scfla_pkg::dp_stat_t                     sts,
    input  wire logic [scfla_pkg::CLS_W-1:0]        cfg_last_class,
    input  wire logic [scfla_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [scfla_pkg::SIZE_W-1:0]       s_req_size,
    input  wire logic [scfla_pkg::ADDR_W-1:0]       s_block_addr,
    input  wire logic                               s_addr_present,
    output logic      [scfla_pkg::ADDR_W-1:0]       m_result_addr,
    output logic                                    m_result_present,
    output logic      [scfla_pkg::STAT_W-1:0]       m_status
);

    // Configuration and request registers
    logic [scfla_pkg::CLS_W-1:0]  last_class_reg, last_class_next;
    logic [scfla_pkg::CMD_W-1:0]  in_cmd_reg;
    logic [scfla_pkg::SIZE_W-1:0] in_size_reg;
    logic [scfla_pkg::ADDR_W-1:0] in_blk_reg;
    logic                         in_present_reg;
    logic [scfla_pkg::WORD_W-1:0] head_reg;

    // Chain builder
    logic [scfla_pkg::WORD_W-1:0]   sw_word_reg, sw_word_next;
    logic [scfla_pkg::CLS_W-1:0]    sw_phase_reg, sw_phase_next;
    logic [scfla_pkg::AIDX_W-1:0]   sw_arena;
    logic [scfla_pkg::ARENA_SH-1:0] sw_off;
    logic [scfla_pkg::ARENA_SH:0]   sw_fit_sum;
    logic                           sw_small, sw_small_fit, sw_lblock, sw_lfit;
    logic [scfla_pkg::WORD_W-1:0]   sw_small_link, sw_large_link, sw_lbase, sw_lofs, sw_val;

    // Request decode
    logic [scfla_pkg::WORD_W-1:0] word, base_new, base_old;
    logic [scfla_pkg::AIDX_W-1:0] p_arena;
    logic [scfla_pkg::CLS_W-1:0]  ptr_cls, size_cls;
    logic [scfla_pkg::SIZE_W-1:0] size_m1;
    logic [scfla_pkg::SCLS_W-1:0] s_raw;

    // Link memory ports
    logic                         ram_we, ram_re;
    logic [scfla_pkg::WORD_W-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    // Result registers
    logic [scfla_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic                         m_present_reg, m_present_next;
    scfla_pkg::status_t           m_status_reg, m_status_next;

    // Configuration register
    always_comb begin
        last_class_next = last_class_reg;
        if (ctl.cfg_load) begin
            last_class_next = cfg_last_class;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_class_reg <= scfla_pkg::LAST_CLASS_RST;
        end else begin
            last_class_reg <= last_class_next;
        end
    end

    // Capture the request and the popped head
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            in_cmd_reg     <= s_cmd;
            in_size_reg    <= s_req_size;
            in_blk_reg     <= s_block_addr;
            in_present_reg <= s_addr_present;
        end
        if (ctl.load_head) begin
            head_reg <= ram_rdata;
        end
    end

    // Builder: arena and block position of the word being written
    assign sw_arena = sw_word_reg[scfla_pkg::WORD_W-1:scfla_pkg::ARENA_SH];
    assign sw_off   = sw_word_reg[scfla_pkg::ARENA_SH-1:0];
    assign sw_small = sw_arena < scfla_pkg::AIDX_W'(last_class_reg);

    // Small class: block of (arena+1) words, link onward while the next one starts inside the arena
    assign sw_fit_sum = (scfla_pkg::ARENA_SH+1)'(sw_off) + (scfla_pkg::ARENA_SH+1)'(sw_arena)
                      + (scfla_pkg::ARENA_SH+1)'(1);
    assign sw_small_fit  = sw_fit_sum < (scfla_pkg::ARENA_SH+1)'(scfla_pkg::ARENA_WORDS);
    assign sw_small_link = sw_word_reg + scfla_pkg::WORD_W'(sw_arena) + scfla_pkg::WORD_W'(1);

    // Large class: fixed blocks from its base, stopping one block short of the heap end
    assign sw_lbase = scfla_pkg::WORD_W'({last_class_reg, {scfla_pkg::ARENA_SH{1'b0}}});
    assign sw_lofs  = sw_word_reg - sw_lbase;
    assign sw_lblock = (sw_lofs & scfla_pkg::WORD_W'(scfla_pkg::LARGE_MASK)) == '0;
    assign sw_lfit   = sw_word_reg < scfla_pkg::WORD_W'(scfla_pkg::LARGE_CONT_LIMIT);
    assign sw_large_link = sw_word_reg + scfla_pkg::WORD_W'(scfla_pkg::LARGE_BLOCK_WORDS);

    always_comb begin
        if (sw_small) begin
            sw_val = (sw_phase_reg == '0 && sw_small_fit) ? sw_small_link : '0;
        end else begin
            sw_val = (sw_lblock && sw_lfit) ? sw_large_link : '0;
        end
    end

    // Advance the builder; the phase counts words within the current small block
    always_comb begin
        sw_word_next  = sw_word_reg;
        sw_phase_next = sw_phase_reg;
        if (ctl.cfg_load) begin
            sw_word_next  = '0;
            sw_phase_next = '0;
        end else if (ctl.sweep_step) begin
            sw_word_next = sw_word_reg + 1'b1;
            if (sw_off == '1 || scfla_pkg::AIDX_W'(sw_phase_reg) == sw_arena) begin
                sw_phase_next = '0;
            end else begin
                sw_phase_next = sw_phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_word_reg  <= '0;
            sw_phase_reg <= '0;
        end else begin
            sw_word_reg  <= sw_word_next;
            sw_phase_reg <= sw_phase_next;
        end
    end

    // Decode block class and size class, both saturated at the large class
    assign word    = in_blk_reg[scfla_pkg::ADDR_W-1:scfla_pkg::BYTE_SH];
    assign p_arena = word[scfla_pkg::WORD_W-1:scfla_pkg::ARENA_SH];
    assign ptr_cls = (p_arena > scfla_pkg::AIDX_W'(last_class_reg)) ? last_class_reg
                                                                    : scfla_pkg::CLS_W'(p_arena);
    assign size_m1  = in_size_reg - 1'b1;
    assign s_raw    = size_m1[scfla_pkg::SIZE_W-1:scfla_pkg::BYTE_SH];
    assign size_cls = (s_raw > scfla_pkg::SCLS_W'(last_class_reg)) ? last_class_reg
                                                                   : scfla_pkg::CLS_W'(s_raw);
    assign base_new = scfla_pkg::WORD_W'({size_cls, {scfla_pkg::ARENA_SH{1'b0}}});
    assign base_old = scfla_pkg::WORD_W'({ptr_cls, {scfla_pkg::ARENA_SH{1'b0}}});

    // Status toward the controller
    always_comb begin
        sts.cmd          = in_cmd_reg;
        sts.addr_present = in_present_reg;
        sts.size_zero    = in_size_reg == '0;
        sts.blk_invalid  = word == base_old;
        sts.same_class   = ptr_cls == size_cls;
        sts.head_zero    = ram_rdata == '0;
        sts.sweep_last   = sw_word_reg == '1;
    end

    // Link memory read address
    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = base_new;
        case (ctl.rd_sel)
            scfla_pkg::RD_NONE:     ram_re    = 1'b0;
            scfla_pkg::RD_BASE_NEW: ram_raddr = base_new;
            scfla_pkg::RD_BASE_OLD: ram_raddr = base_old;
            scfla_pkg::RD_LINK:     ram_raddr = ram_rdata;
            default:                ram_re    = 1'b0;
        endcase
    end

    // Link memory write address and data
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = sw_word_reg;
        ram_wdata = sw_val;
        case (ctl.wr_sel)
            scfla_pkg::WR_NONE:     ram_we = 1'b0;
            scfla_pkg::WR_SWEEP: begin
                ram_waddr = sw_word_reg;
                ram_wdata = sw_val;
            end
            scfla_pkg::WR_BASE_NEW: begin
                ram_waddr = base_new;
                ram_wdata = ram_rdata;
            end
            scfla_pkg::WR_HEAD_CLR: begin
                ram_waddr = head_reg;
                ram_wdata = '0;
            end
            scfla_pkg::WR_WORD: begin
                ram_waddr = word;
                ram_wdata = ram_rdata;
            end
            scfla_pkg::WR_BASE_OLD: begin
                ram_waddr = base_old;
                ram_wdata = word;
            end
            default:                ram_we = 1'b0;
        endcase
    end

    scfla_ram #(
        .WIDTH(scfla_pkg::WORD_W),
        .DEPTH(scfla_pkg::HEAP_WORDS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result: granted block, kept block, or nothing
    always_comb begin
        m_addr_next    = m_addr_reg;
        m_present_next = m_present_reg;
        m_status_next  = m_status_reg;
        if (ctl.load_out) begin
            m_status_next = ctl.out_status;
            case (ctl.out_status)
                scfla_pkg::STAT_ALLOC, scfla_pkg::STAT_MOVED: begin
                    m_addr_next    = {head_reg, {scfla_pkg::BYTE_SH{1'b0}}};
                    m_present_next = 1'b1;
                end
                scfla_pkg::STAT_KEPT: begin
                    m_addr_next    = in_blk_reg;
                    m_present_next = 1'b1;
                end
                default: begin
                    m_addr_next    = '0;
                    m_present_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_addr_reg    <= '0;
            m_present_reg <= 1'b0;
            m_status_reg  <= scfla_pkg::STAT_NULL;
        end else begin
            m_addr_reg    <= m_addr_next;
            m_present_reg <= m_present_next;
            m_status_reg  <= m_status_next;
        end
    end

    assign m_result_addr    = m_addr_reg;
    assign m_result_present = m_present_reg;
    assign m_status         = m_status_reg;

    // A result carries a block only for allocate, move or keep
    a_present_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_present_reg |-> (m_status_reg == scfla_pkg::STAT_ALLOC ||
                           m_status_reg == scfla_pkg::STAT_MOVED ||
                           m_status_reg == scfla_pkg::STAT_KEPT))
        else $error("result block present with a non-granting status");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_present_reg |-> m_addr_reg == '0)
        else $error("empty result with a nonzero address");

    // Only a real popped head is cleared, and a list head never links to itself
    a_clear_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_sel == scfla_pkg::WR_HEAD_CLR |-> head_reg != '0)
        else $error("clearing the link of a null head");

    a_push_self: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_sel == scfla_pkg::WR_BASE_OLD |-> word != base_old)
        else $error("pushing a list head onto its own list");

endmodule

`default_nettype wire

// File: rtl/core/scfla_ctrl.sv
// Allocator controller: request sequencing, chain rebuild and handshakes.
`default_nettype none

module scfla_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    output scfla_pkg::dp_cmd_t       ctl,
    input  wire scfla_pkg::dp_stat_t sts
);

    typedef enum logic [9:0] {
        S_INIT      = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_EVAL      = 10'b0000000100,
        S_POP_HEAD  = 10'b0000001000,
        S_POP_LINK  = 10'b0000010000,
        S_POP_CLR   = 10'b0000100000,
        S_PUSH_BASE = 10'b0001000000,
        S_PUSH_LINK = 10'b0010000000,
        S_PUSH_HEAD = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    scfla_pkg::status_t res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic               alloc_path;

    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    // Sequence one request through pop and push steps
    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        alloc_path     = 1'b0;
        ctl            = '0;
        ctl.rd_sel     = scfla_pkg::RD_NONE;
        ctl.wr_sel     = scfla_pkg::WR_NONE;
        ctl.out_status = res_reg;

        case (state_reg)
            S_INIT: begin
                ctl.wr_sel     = scfla_pkg::WR_SWEEP;
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_DONE;
                res_next   = scfla_pkg::STAT_NULL;
                case (sts.cmd)
                    scfla_pkg::CMD_ALLOC: alloc_path = 1'b1;
                    scfla_pkg::CMD_FREE: begin
                        if (sts.addr_present && !sts.blk_invalid) begin
                            ctl.rd_sel = scfla_pkg::RD_BASE_OLD;
                            res_next   = scfla_pkg::STAT_FREED;
                            state_next = S_PUSH_LINK;
                        end else begin
                            res_next = scfla_pkg::STAT_IGNORED;
                        end
                    end
                    scfla_pkg::CMD_REALLOC: begin
                        if (!sts.addr_present) begin
                            alloc_path = 1'b1;
                        end else if (sts.size_zero || sts.blk_invalid) begin
                            res_next = scfla_pkg::STAT_NULL;
                        end else if (sts.same_class) begin
                            res_next = scfla_pkg::STAT_KEPT;
                        end else begin
                            ctl.rd_sel = scfla_pkg::RD_BASE_NEW;
                            res_next   = scfla_pkg::STAT_MOVED;
                            state_next = S_POP_HEAD;
                        end
                    end
                    default: res_next = scfla_pkg::STAT_NULL;
                endcase
                if (alloc_path && !sts.size_zero) begin
                    ctl.rd_sel = scfla_pkg::RD_BASE_NEW;
                    res_next   = scfla_pkg::STAT_ALLOC;
                    state_next = S_POP_HEAD;
                end
            end
            S_POP_HEAD: begin
                // Empty list: give up; on a move the old block stays where it is
                if (sts.head_zero) begin
                    res_next   = scfla_pkg::STAT_NULL;
                    state_next = S_DONE;
                end else begin
                    ctl.load_head = 1'b1;
                    ctl.rd_sel    = scfla_pkg::RD_LINK;
                    state_next    = S_POP_LINK;
                end
            end
            S_POP_LINK: begin
                ctl.wr_sel = scfla_pkg::WR_BASE_NEW;
                state_next = S_POP_CLR;
            end
            S_POP_CLR: begin
                ctl.wr_sel = scfla_pkg::WR_HEAD_CLR;
                state_next = (res_reg == scfla_pkg::STAT_MOVED) ? S_PUSH_BASE : S_DONE;
            end
            S_PUSH_BASE: begin
                ctl.rd_sel = scfla_pkg::RD_BASE_OLD;
                state_next = S_PUSH_LINK;
            end
            S_PUSH_LINK: begin
                ctl.wr_sel = scfla_pkg::WR_WORD;
                state_next = S_PUSH_HEAD;
            end
            S_PUSH_HEAD: begin
                ctl.wr_sel = scfla_pkg::WR_BASE_OLD;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register frees up
                if (!m_valid_reg || m_ready) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase

        // A register write restarts the chain rebuild
        if (cfg_valid) begin
            ctl.cfg_load = 1'b1;
            state_next   = S_INIT;
        end
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            res_reg     <= scfla_pkg::STAT_NULL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // One request in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_result_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    // Link write of a pop only follows the head read
    a_pop_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_LINK |-> $past(state_reg == S_POP_HEAD))
        else $error("pop link step without a head read");

endmodule

`default_nettype wire

// File: rtl/core/size_class_free_list_allocator.sv
// Size-zero, invalid, kept and cmd 3 requests go from evaluation straight to the result; a free
// reads the old list head and pushes the block; an allocate pops the head of its class list,
// giving up on an empty list; a moving reallocate pops, then pushes, each step a dependent
// link-memory read or write. One request at a time: the next is taken once the result has loaded
// and the controller is idle. Reset (aresetn, synchronous, active low) and every last_class write
// rebuild the free lists over the link memory, one word a cycle; no request is taken meanwhile.
`default_nettype none

module size_class_free_list_allocator (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [scfla_pkg::CMD_W-1:0]  s_cmd,
    input  wire logic [scfla_pkg::SIZE_W-1:0] s_req_size,
    input  wire logic [scfla_pkg::ADDR_W-1:0] s_block_addr,
    input  wire logic                         s_addr_present,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [scfla_pkg::ADDR_W-1:0] m_result_addr,
    output logic                              m_result_present,
    output logic      [scfla_pkg::STAT_W-1:0] m_status,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [scfla_pkg::CLS_W-1:0]  cfg_last_class
);

    scfla_pkg::dp_cmd_t  ctl;
    scfla_pkg::dp_stat_t sts;

    scfla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    scfla_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .sts              (sts),
        .cfg_last_class   (cfg_last_class),
        .s_cmd            (s_cmd),
        .s_req_size       (s_req_size),
        .s_block_addr     (s_block_addr),
        .s_addr_present   (s_addr_present),
        .m_result_addr    (m_result_addr),
        .m_result_present (m_result_present),
        .m_status         (m_status)
    );

endmodule

`default_nettype wire

// File: tb/size_class_free_list_allocator_tb.sv
// Testbench for the size-class free-list allocator: directed and random requests.
module size_class_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 4 * scfla_pkg::HEAP_WORDS;
    localparam int ITEMS_PER_PHASE = 345;
    localparam int POOL_HIGH       = 150;

    localparam logic [scfla_pkg::CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam logic [scfla_pkg::CLS_W-1:0] LAST_CLASS_MIN = scfla_pkg::CLS_W'(7);
    localparam logic [scfla_pkg::CLS_W-1:0] LAST_CLASS_MID = scfla_pkg::CLS_W'(22);
    localparam logic [scfla_pkg::CLS_W-1:0] LAST_CLASS_MAX = scfla_pkg::CLS_W'(31);

    typedef struct packed {
        logic [scfla_pkg::ADDR_W-1:0] addr;
        logic                         present;
        scfla_pkg::status_t           status;
    } grant_t;

    // Predicts each request's result from a private copy of the free lists
    class alloc_scoreboard;
        logic [scfla_pkg::WORD_W-1:0] next_free [scfla_pkg::HEAP_WORDS];
        int unsigned                  large_cls;
        grant_t                       expected_q[$];
        int                           errors;

        function new();
            errors = 0;
            set_large_class(scfla_pkg::LAST_CLASS_RST);
        endfunction

        // Clear the links and chain every class again, large class last
        function void set_large_class(int unsigned cls);
            int unsigned c, base, step, cap, w;
            large_cls = cls;
            foreach (next_free[i]) next_free[i] = '0;
            for (c = 0; c <= large_cls; c++) begin
                base = c * scfla_pkg::ARENA_WORDS;
                if (base < scfla_pkg::HEAP_WORDS) begin
                    if (c == large_cls) begin
                        step = scfla_pkg::LARGE_BLOCK_WORDS;
                        cap  = scfla_pkg::HEAP_WORDS - scfla_pkg::LARGE_BLOCK_WORDS;
                    end else begin
                        step = c + 1;
                        cap  = (c + 1) * scfla_pkg::ARENA_WORDS;
                        if (cap > scfla_pkg::HEAP_WORDS) cap = scfla_pkg::HEAP_WORDS;
                    end
                    w = base;
                    while (w + step < cap) begin
                        next_free[w] = scfla_pkg::WORD_W'(w + step);
                        w += step;
                    end
                    next_free[w] = '0;
                end
            end
        endfunction

        function int unsigned class_of_size(int unsigned size);
            int unsigned c;
            c = (size - 1) / 8;
            return (c > large_cls) ? large_cls : c;
        endfunction

        function int unsigned class_of_word(int unsigned word);
            int unsigned c;
            c = word / scfla_pkg::ARENA_WORDS;
            return (c > large_cls) ? large_cls : c;
        endfunction

        // A list head is never a block
        function bit is_block(int unsigned word);
            return word < scfla_pkg::HEAP_WORDS &&
                   word != class_of_word(word) * scfla_pkg::ARENA_WORDS;
        endfunction

        // Unlink the head of a class list; 0 when the list is empty
        function int unsigned pop_block(int unsigned c);
            int unsigned base, head;
            base = c * scfla_pkg::ARENA_WORDS;
            if (base >= scfla_pkg::HEAP_WORDS) return 0;
            head = next_free[base];
            if (head == 0) return 0;
            next_free[base] = next_free[head];
            next_free[head] = '0;
            return head;
        endfunction

        function void push_block(int unsigned word);
            int unsigned base;
            base = class_of_word(word) * scfla_pkg::ARENA_WORDS;
            next_free[word] = next_free[base];
            next_free[base] = scfla_pkg::WORD_W'(word);
        endfunction

        // Apply an accepted request and queue the result it must produce
        function void note_request(logic [scfla_pkg::CMD_W-1:0] cmd,
                                   logic [scfla_pkg::SIZE_W-1:0] size,
                                   logic [scfla_pkg::ADDR_W-1:0] addr, logic present);
            int unsigned word, fresh;
            grant_t g;
            word = addr >> scfla_pkg::BYTE_SH;
            g = '{'0, 1'b0, scfla_pkg::STAT_NULL};
            if (cmd == scfla_pkg::CMD_ALLOC || (cmd == scfla_pkg::CMD_REALLOC && !present)) begin
                if (size != 0) begin
                    fresh = pop_block(class_of_size(size));
                    if (fresh != 0) begin
                        g = '{scfla_pkg::ADDR_W'(fresh << scfla_pkg::BYTE_SH), 1'b1,
                              scfla_pkg::STAT_ALLOC};
                    end
                end
            end else if (cmd == scfla_pkg::CMD_FREE) begin
                g.status = scfla_pkg::STAT_IGNORED;
                if (present && is_block(word)) begin
                    push_block(word);
                    g.status = scfla_pkg::STAT_FREED;
                end
            end else if (cmd == scfla_pkg::CMD_REALLOC && size != 0 && is_block(word)) begin
                if (class_of_word(word) == class_of_size(size)) begin
                    g = '{addr, 1'b1, scfla_pkg::STAT_KEPT};
                end else begin
                    fresh = pop_block(class_of_size(size));
                    if (fresh != 0) begin
                        push_block(word);
                        g = '{scfla_pkg::ADDR_W'(fresh << scfla_pkg::BYTE_SH), 1'b1,
                              scfla_pkg::STAT_MOVED};
                    end
                end
            end
            expected_q.push_back(g);
        endfunction

        // Compare a result with the oldest outstanding prediction
        function void check_result(logic [scfla_pkg::ADDR_W-1:0] addr, logic present,
                                   logic [scfla_pkg::STAT_W-1:0] status);
            grant_t g;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: addr %0h status %0d", addr, status);
                errors++;
                return;
            end
            g = expected_q.pop_front();
            if (status !== g.status) begin
                $error("status: expected %0d, got %0d", g.status, status);
                errors++;
            end
            if (present !== g.present) begin
                $error("result_present: expected %0b, got %0b", g.present, present);
                errors++;
            end
            if (addr !== g.addr) begin
                $error("result_addr: expected %0h, got %0h", g.addr, addr);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [scfla_pkg::CMD_W-1:0]    s_cmd;
    logic [scfla_pkg::SIZE_W-1:0]   s_req_size;
    logic [scfla_pkg::ADDR_W-1:0]   s_block_addr;
    logic                           s_addr_present;
    logic                           m_valid;
    logic                           m_ready;
    logic [scfla_pkg::ADDR_W-1:0]   m_result_addr;
    logic                           m_result_present;
    logic [scfla_pkg::STAT_W-1:0]   m_status;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [scfla_pkg::CLS_W-1:0]    cfg_last_class;

    alloc_scoreboard                sb;
    logic [scfla_pkg::ADDR_W-1:0]   live_blocks[$];
    logic [scfla_pkg::ADDR_W:0]     origin_q[$];
    logic [scfla_pkg::ADDR_W-1:0]   last_freed;
    int unsigned                    cur_last;
    bit                             sender_fast;
    int                             quiet_cycles;

    size_class_free_list_allocator DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_req_size       (s_req_size),
        .s_block_addr     (s_block_addr),
        .s_addr_present   (s_addr_present),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_addr    (m_result_addr),
        .m_result_present (m_result_present),
        .m_status         (m_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_last_class   (cfg_last_class)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly sizes of the small classes, some large, a few zero
    function automatic logic [scfla_pkg::SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 88) return scfla_pkg::SIZE_W'($urandom_range(1, cur_last * 8));
        if (r < 96) return scfla_pkg::SIZE_W'($urandom_range(cur_last * 8 + 1, 4096));
        return scfla_pkg::SIZE_W'($urandom_range(4097, (1 << scfla_pkg::SIZE_W) - 1));
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic offer_request(input logic [scfla_pkg::CMD_W-1:0] cmd,
                                 input logic [scfla_pkg::SIZE_W-1:0] size,
                                 input logic [scfla_pkg::ADDR_W-1:0] addr, input logic present,
                                 input bit tracked = 1'b0);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_req_size     <= size;
        s_block_addr   <= addr;
        s_addr_present <= present;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_request(cmd, size, addr, present);
        origin_q.push_back({tracked, addr});
    endtask

    // Drop valid and wait until every outstanding request has its result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_last_class(input logic [scfla_pkg::CLS_W-1:0] cls);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_last_class <= cls;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_large_class(cls);
        cur_last = cls;
    endtask

    // Mostly well-formed traffic over granted blocks, with some noise
    task automatic run_random(input int count);
        int                           i, r, pick, alloc_cut;
        int unsigned                  cls;
        logic [scfla_pkg::ADDR_W-1:0] addr;
        logic [scfla_pkg::SIZE_W-1:0] size;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) sender_fast = ($urandom_range(0, 3) == 0);
            if (i == count / 3) drain();
            r = $urandom_range(0, 99);
            alloc_cut = (live_blocks.size() > POOL_HIGH) ? 20 : 40;
            if (r < alloc_cut || (live_blocks.size() == 0 && r < 85)) begin
                offer_request(scfla_pkg::CMD_ALLOC, pick_size(), scfla_pkg::ADDR_W'($urandom),
                              1'($urandom));
            end else if (r < 65) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[pick];
                live_blocks.delete(pick);
                last_freed = addr;
                offer_request(scfla_pkg::CMD_FREE, scfla_pkg::SIZE_W'($urandom), addr, 1'b1);
            end else if (r < 85) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[pick];
                live_blocks.delete(pick);
                cls = (addr >> scfla_pkg::BYTE_SH) / scfla_pkg::ARENA_WORDS;
                if ($urandom_range(0, 2) != 0) begin
                    size = pick_size();
                end else if (cls >= cur_last) begin
                    size = scfla_pkg::SIZE_W'($urandom_range(cur_last * 8 + 1, 4096));
                end else begin
                    size = scfla_pkg::SIZE_W'($urandom_range(cls * 8 + 1, cls * 8 + 8));
                end
                offer_request(scfla_pkg::CMD_REALLOC, size, addr, 1'b1, 1'b1);
            end else begin
                case ($urandom_range(0, 5))
                    0: offer_request(CMD_UNUSED, scfla_pkg::SIZE_W'($urandom),
                                     scfla_pkg::ADDR_W'($urandom), 1'($urandom));
                    1: offer_request(scfla_pkg::CMD_FREE, scfla_pkg::SIZE_W'($urandom),
                                     scfla_pkg::ADDR_W'($urandom), 1'b1);
                    2: offer_request(scfla_pkg::CMD_FREE, scfla_pkg::SIZE_W'($urandom),
                                     scfla_pkg::ADDR_W'($urandom), 1'b0);
                    3: offer_request(scfla_pkg::CMD_REALLOC, pick_size(),
                                     scfla_pkg::ADDR_W'($urandom), 1'b0);
                    4: offer_request(($urandom_range(0, 1) != 0) ? scfla_pkg::CMD_FREE
                                                                 : scfla_pkg::CMD_REALLOC,
                                     pick_size(),
                                     scfla_pkg::ADDR_W'($urandom_range(0, cur_last + 2) *
                                                        scfla_pkg::ARENA_WORDS * 8),
                                     1'b1);
                    default: offer_request(scfla_pkg::CMD_FREE, scfla_pkg::SIZE_W'($urandom),
                                           last_freed, 1'b1);
                endcase
            end
        end
    endtask

    // Accept results after random holds and feed granted blocks back to the pool
    initial begin : result_side
        int                         gap;
        int                         n_results;
        logic [scfla_pkg::ADDR_W:0] origin;
        n_results = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 18);
            if ((n_results / 40) % 4 == 1) gap = 0;
            if (n_results % 600 == 200) gap = LONG_HOLD;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            sb.check_result(m_result_addr, m_result_present, m_status);
            n_results++;
            origin = (origin_q.size() != 0) ? origin_q.pop_front() : '0;
            if (m_result_present && (m_status == scfla_pkg::STAT_ALLOC ||
                                     m_status == scfla_pkg::STAT_MOVED)) begin
                live_blocks.push_back(m_result_addr);
            end
            // keep the old block when a reallocate left it in place
            if (origin[scfla_pkg::ADDR_W] && (m_status == scfla_pkg::STAT_KEPT ||
                                              m_status == scfla_pkg::STAT_NULL)) begin
                live_blocks.push_back(origin[scfla_pkg::ADDR_W-1:0]);
            end
        end
    end

    initial begin : stimulus
        s_valid        <= 1'b0;
        s_cmd          <= scfla_pkg::CMD_ALLOC;
        s_req_size     <= '0;
        s_block_addr   <= '0;
        s_addr_present <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_last_class <= scfla_pkg::LAST_CLASS_RST;
        aresetn        <= 1'b0;
        sb          = new();
        cur_last    = scfla_pkg::LAST_CLASS_RST;
        last_freed  = '0;
        sender_fast = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // size extremes and class boundaries
        offer_request(scfla_pkg::CMD_ALLOC, '0, '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, scfla_pkg::SIZE_W'(1), '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, scfla_pkg::SIZE_W'(8), '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, scfla_pkg::SIZE_W'(9), '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, scfla_pkg::SIZE_W'(120), '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, scfla_pkg::SIZE_W'(121), '0, 1'b0);
        offer_request(scfla_pkg::CMD_ALLOC, '1, '0, 1'b0);
        // frees to drop: null pointer and list heads
        offer_request(scfla_pkg::CMD_FREE, '0, '1, 1'b0);
        offer_request(scfla_pkg::CMD_FREE, '0, '0, 1'b1);
        offer_request(scfla_pkg::CMD_FREE, '0,
                      scfla_pkg::ADDR_W'(3 * scfla_pkg::ARENA_WORDS * 8), 1'b1);
        offer_request(scfla_pkg::CMD_FREE, '0,
                      scfla_pkg::ADDR_W'(15 * scfla_pkg::ARENA_WORDS * 8), 1'b1);
        // real frees, a stray top-of-heap one and one with low bits set
        offer_request(scfla_pkg::CMD_FREE, '0, scfla_pkg::ADDR_W'(8), 1'b1);
        offer_request(scfla_pkg::CMD_FREE, '1, '1, 1'b1);
        offer_request(scfla_pkg::CMD_FREE, '0, scfla_pkg::ADDR_W'(3 * 8 + 7), 1'b1);
        // reallocate: null pointer, zero size, list head, kept, moved both ways
        offer_request(scfla_pkg::CMD_REALLOC, scfla_pkg::SIZE_W'(24), '1, 1'b0);
        offer_request(scfla_pkg::CMD_REALLOC, '0, '0, 1'b0);
        offer_request(scfla_pkg::CMD_REALLOC, '0,
                      scfla_pkg::ADDR_W'((scfla_pkg::ARENA_WORDS + 2) * 8), 1'b1);
        offer_request(scfla_pkg::CMD_REALLOC, scfla_pkg::SIZE_W'(16),
                      scfla_pkg::ADDR_W'(2 * scfla_pkg::ARENA_WORDS * 8), 1'b1);
        offer_request(scfla_pkg::CMD_REALLOC, scfla_pkg::SIZE_W'(16),
                      scfla_pkg::ADDR_W'((scfla_pkg::ARENA_WORDS + 2) * 8 + 5), 1'b1);
        offer_request(scfla_pkg::CMD_REALLOC, scfla_pkg::SIZE_W'(40),
                      scfla_pkg::ADDR_W'((scfla_pkg::ARENA_WORDS + 2) * 8), 1'b1);
        offer_request(scfla_pkg::CMD_REALLOC, scfla_pkg::SIZE_W'(1),
                      scfla_pkg::ADDR_W'((15 * scfla_pkg::ARENA_WORDS +
                                          scfla_pkg::LARGE_BLOCK_WORDS) * 8), 1'b1);
        offer_request(CMD_UNUSED, '1, '1, 1'b1);

        run_random(ITEMS_PER_PHASE);
        write_last_class(LAST_CLASS_MAX);
        run_random(ITEMS_PER_PHASE);
        write_last_class(LAST_CLASS_MIN);
        run_random(ITEMS_PER_PHASE);
        write_last_class(LAST_CLASS_MID);
        run_random(ITEMS_PER_PHASE);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
